// File: hdl/sdo_segmented_download_client_unit_assert.svh
// Assertion macros for the segmented SDO download client.
// Used by sdo_engine in this folder; the clock and reset are i_clk and i_rst_n.
`ifndef SDO_SEGMENTED_DOWNLOAD_CLIENT_UNIT_ASSERT_SVH
`define SDO_SEGMENTED_DOWNLOAD_CLIENT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SDO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("SDO client assertion failed");
`define SDO_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("SDO client reset assertion failed");
`else
`define SDO_ASSERT(lbl, prop)
`define SDO_ASSERT_RST(lbl, prop)
`endif
`endif

// File: hdl/sdo_pkg.sv
// Package for the segmented SDO download client: transfer types, codes and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sdo_pkg;

    localparam logic [2:0]  SEG_BYTES   = 3'd7;

    localparam logic [10:0] TX_ID_BASE  = 11'h600;
    localparam logic [10:0] RX_ID_BASE  = 11'h580;

    localparam logic [7:0]  CMD_INIT     = 8'h21;
    localparam logic [7:0]  CMD_INIT_ACK = 8'h60;
    localparam logic [7:0]  CMD_ABORT    = 8'h80;
    localparam logic [7:0]  CMD_SEG_ACK0 = 8'h20;
    localparam logic [7:0]  CMD_SEG_ACK1 = 8'h30;

    localparam logic [3:0]  DLC_INIT_MIN = 4'd4;
    localparam logic [3:0]  DLC_SEG_MIN  = 4'd1;

    localparam logic [1:0]  REQ_START   = 2'd0;
    localparam logic [1:0]  REQ_DATA    = 2'd1;
    localparam logic [1:0]  REQ_REPLY   = 2'd2;
    localparam logic [1:0]  REQ_TIMEOUT = 2'd3;

    localparam logic [2:0]  ST_READY   = 3'd0;
    localparam logic [2:0]  ST_DONE    = 3'd1;
    localparam logic [2:0]  ST_BAD_ACK = 3'd2;
    localparam logic [2:0]  ST_ABORT   = 3'd3;
    localparam logic [2:0]  ST_TIMEOUT = 3'd4;
    localparam logic [2:0]  ST_BAD_REQ = 3'd5;
    localparam logic [2:0]  ST_SENT    = 3'd6;

    localparam logic [1:0]  REG_NODE_ID     = 2'd0;
    localparam logic [1:0]  REG_OD_INDEX    = 2'd1;
    localparam logic [1:0]  REG_OD_SUBINDEX = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_WAIT_INIT = 4'b0010,
        PH_GATHER    = 4'b0100,
        PH_WAIT_SEG  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] total_size;
        logic [7:0]  data_byte;
        logic [10:0] rx_id;
        logic [3:0]  rx_dlc;
        logic [7:0]  rx_byte0;
        logic [7:0]  rx_byte1;
        logic [7:0]  rx_byte2;
        logic [7:0]  rx_byte3;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [10:0] tx_id;
        logic [7:0]  tx_byte0;
        logic [7:0]  tx_byte1;
        logic [7:0]  tx_byte2;
        logic [7:0]  tx_byte3;
        logic [7:0]  tx_byte4;
        logic [7:0]  tx_byte5;
        logic [7:0]  tx_byte6;
        logic [7:0]  tx_byte7;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  node_id;
        logic [15:0] od_index;
        logic [7:0]  od_subindex;
    } t_cfg;

    function automatic logic [2:0] seg_len(input logic [31:0] remaining);
        seg_len = (remaining > {29'd0, SEG_BYTES}) ? SEG_BYTES : remaining[2:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/sdo_segmented_download_client_unit.sv
// Top level of the segmented SDO download client: input and result registers.
// Depends on sdo_pkg, sdo_cfg_regs and sdo_engine.
//
//  Channel   Direction  Handshake                       Transfer
//  in        to block   i_in_valid / o_in_ready         t_in_item, one event
//  out       from block o_out_valid / i_out_ready       t_out_item, zero or one per event
//  cfg       to block   psel, penable, pwrite / pready  32-bit register write or read
//
// An item is held in the input register and its result, if any, is registered in the
// result register when the item advances; one item is taken every cycle while the
// result register is empty or being taken. A full result register that is not taken
// stalls the input register, which then holds its item. Reset is synchronous and leaves
// the block idle with node 1 selected; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sdo_segmented_download_client_unit
    import sdo_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    logic      res_valid;
    t_out_item res;
    t_cfg      cfg;

    sdo_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sdo_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// File: hdl/sdo_cfg_regs.sv
// Configuration registers of the SDO download client behind an APB-style port.
// Depends on sdo_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module sdo_cfg_regs
    import sdo_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [6:0]  r_node_id;
    logic [15:0] r_od_index;
    logic [7:0]  r_od_subindex;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= 7'd1;
            r_od_index    <= 16'd0;
            r_od_subindex <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_NODE_ID:     r_node_id     <= pwdata[6:0];
                REG_OD_INDEX:    r_od_index    <= pwdata[15:0];
                REG_OD_SUBINDEX: r_od_subindex <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NODE_ID:     prdata = {25'd0, r_node_id};
            REG_OD_INDEX:    prdata = {16'd0, r_od_index};
            REG_OD_SUBINDEX: prdata = {24'd0, r_od_subindex};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{node_id: r_node_id, od_index: r_od_index, od_subindex: r_od_subindex};

endmodule

`default_nettype wire

// File: hdl/sdo_engine.sv
// Transfer state and result logic of the SDO download client, one item per cycle while i_step is high.
// Depends on sdo_pkg and on the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sdo_segmented_download_client_unit_assert.svh"

module sdo_engine
    import sdo_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output logic           o_res_valid,
    output t_out_item      o_res
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_remaining, n_remaining;
    logic        r_toggle, n_toggle;
    logic [2:0]  r_fill, n_fill;
    logic [2:0]  r_target, n_target;
    logic [7:0]  r_store [SEG_BYTES];
    logic [7:0]  n_store [SEG_BYTES];
    logic        store_wr;
    logic [10:0] expect_id;
    logic [10:0] tx_id;
    logic [31:0] rem_after;
    logic        last_seg;
    logic [2:0]  unused_cnt;
    logic [7:0]  seg_bytes [SEG_BYTES];

    assign expect_id  = RX_ID_BASE + {4'd0, i_cfg.node_id};
    assign tx_id      = TX_ID_BASE + {4'd0, i_cfg.node_id};
    assign rem_after  = r_remaining - {29'd0, r_target};
    assign last_seg   = (r_remaining <= {29'd0, SEG_BYTES});
    assign unused_cnt = SEG_BYTES - r_remaining[2:0];
    assign n_fill     = r_fill + 3'd1;

    always_comb begin
        for (int i = 0; i < int'(SEG_BYTES); i++) begin
            n_store[i] = r_store[i];
        end
        n_store[r_fill] = i_item.data_byte;
        for (int i = 0; i < int'(SEG_BYTES); i++) begin
            seg_bytes[i] = (3'(i) < n_fill) ? n_store[i] : 8'd0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_toggle    = r_toggle;
        n_target    = r_target;
        store_wr    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step) begin
            o_res_valid  = 1'b1;
            o_res.status = ST_BAD_REQ;
            unique case (i_item.req_type)
                REQ_START: begin
                    if (r_phase == PH_IDLE && i_item.total_size != 32'd0 &&
                        i_cfg.node_id != 7'd0) begin
                        n_remaining    = i_item.total_size;
                        n_toggle       = 1'b0;
                        n_target       = 3'd0;
                        n_phase        = PH_WAIT_INIT;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_id    = tx_id;
                        o_res.tx_byte0 = CMD_INIT;
                        o_res.tx_byte1 = i_cfg.od_index[7:0];
                        o_res.tx_byte2 = i_cfg.od_index[15:8];
                        o_res.tx_byte3 = i_cfg.od_subindex;
                        o_res.tx_byte4 = i_item.total_size[7:0];
                        o_res.tx_byte5 = i_item.total_size[15:8];
                        o_res.tx_byte6 = i_item.total_size[23:16];
                        o_res.tx_byte7 = i_item.total_size[31:24];
                        o_res.status   = ST_SENT;
                    end
                end
                REQ_DATA: begin
                    if (r_phase == PH_GATHER && r_fill < SEG_BYTES) begin
                        store_wr = 1'b1;
                        if (n_fill < r_target) begin
                            o_res_valid = 1'b0;
                        end else begin
                            n_phase        = PH_WAIT_SEG;
                            o_res.tx_valid = 1'b1;
                            o_res.tx_id    = tx_id;
                            o_res.tx_byte0 = last_seg ? {3'd0, r_toggle, unused_cnt, 1'b1}
                                                      : {3'd0, r_toggle, 4'd0};
                            o_res.tx_byte1 = seg_bytes[0];
                            o_res.tx_byte2 = seg_bytes[1];
                            o_res.tx_byte3 = seg_bytes[2];
                            o_res.tx_byte4 = seg_bytes[3];
                            o_res.tx_byte5 = seg_bytes[4];
                            o_res.tx_byte6 = seg_bytes[5];
                            o_res.tx_byte7 = seg_bytes[6];
                            o_res.status   = ST_SENT;
                        end
                    end
                end
                REQ_REPLY: begin
                    if (r_phase == PH_WAIT_INIT) begin
                        n_phase = PH_IDLE;
                        if (i_item.rx_dlc < DLC_INIT_MIN || i_item.rx_id != expect_id) begin
                            o_res.status = ST_BAD_ACK;
                        end else if (i_item.rx_byte0 == CMD_ABORT) begin
                            o_res.status = ST_ABORT;
                        end else if (i_item.rx_byte0 != CMD_INIT_ACK ||
                                     i_item.rx_byte1 != i_cfg.od_index[7:0] ||
                                     i_item.rx_byte2 != i_cfg.od_index[15:8] ||
                                     i_item.rx_byte3 != i_cfg.od_subindex) begin
                            o_res.status = ST_BAD_ACK;
                        end else begin
                            n_target     = seg_len(r_remaining);
                            n_phase      = PH_GATHER;
                            o_res.status = ST_READY;
                        end
                    end else if (r_phase == PH_WAIT_SEG) begin
                        n_phase = PH_IDLE;
                        if (i_item.rx_dlc < DLC_SEG_MIN) begin
                            o_res.status = ST_BAD_ACK;
                        end else if (i_item.rx_byte0 == CMD_ABORT) begin
                            o_res.status = ST_ABORT;
                        end else if (i_item.rx_id != expect_id ||
                                     i_item.rx_byte0 !=
                                     (r_toggle ? CMD_SEG_ACK1 : CMD_SEG_ACK0)) begin
                            o_res.status = ST_BAD_ACK;
                        end else begin
                            n_remaining = rem_after;
                            n_toggle    = ~r_toggle;
                            if (rem_after == 32'd0) begin
                                n_target     = 3'd0;
                                o_res.status = ST_DONE;
                            end else begin
                                n_target     = seg_len(rem_after);
                                n_phase      = PH_GATHER;
                                o_res.status = ST_READY;
                            end
                        end
                    end
                end
                REQ_TIMEOUT: begin
                    if (r_phase == PH_WAIT_INIT || r_phase == PH_WAIT_SEG) begin
                        n_phase      = PH_IDLE;
                        o_res.status = ST_TIMEOUT;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_remaining <= 32'd0;
            r_toggle    <= 1'b0;
            r_fill      <= 3'd0;
            r_target    <= 3'd0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_toggle    <= n_toggle;
            r_target    <= n_target;
            if (store_wr) begin
                r_fill <= n_fill;
            end else if (n_phase != r_phase && (n_phase == PH_GATHER ||
                         n_phase == PH_WAIT_INIT || o_res.status == ST_DONE)) begin
                r_fill <= 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[r_fill] <= i_item.data_byte;
        end
    end

    `SDO_ASSERT(a_gather_fill, (r_phase == PH_GATHER) |-> (r_fill < r_target))
    `SDO_ASSERT(a_gather_target, (r_phase == PH_GATHER) |-> (r_target != 3'd0 && {29'd0, r_target} <= r_remaining))
    `SDO_ASSERT(a_wait_seg_full, (r_phase == PH_WAIT_SEG) |-> (r_fill == r_target && r_fill != 3'd0))
    `SDO_ASSERT(a_done_idle, (i_step && o_res_valid && o_res.status == ST_DONE) |=> (r_phase == PH_IDLE && r_remaining == 32'd0))
    `SDO_ASSERT_RST(a_reset_idle, (!i_rst_n) |=> (r_phase == PH_IDLE))

endmodule

`default_nettype wire
